// ----- rtl/core/cbrs_pkg.sv -----
`timescale 1ns / 1ps

package cbrs_pkg;

	// Payload widths fixed by the interface.
	localparam int IDX_W   = 3;
	localparam int THR_W   = 54;
	localparam int FRAC_W  = 53;
	localparam int SEED_W  = 64;
	localparam int ROOM_W  = 31;
	localparam int WORD_W  = 64;
	localparam int HALF_W  = WORD_W / 2;

	// Stream counter bank.
	localparam int STREAM_COUNT = 8;
	localparam int SEL_W        = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOM = 2'd1;

	// Finalizer constants.
	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] MUL_ONE     = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MUL_TWO     = 64'h94d049bb133111eb;
	localparam logic [WORD_W-1:0] STREAM_BIAS = 64'h0000000100000000;
	localparam logic [WORD_W-1:0] COUNT_BIAS  = 64'h0000000200000000;
	localparam logic [THR_W-1:0]  THR_ONE     = 54'h20000000000000;

	// Queue between front and back.
	localparam int MID_DEPTH  = 2;
	localparam int MID_PTR_W  = 1;
	localparam int MID_FILL_W = 2;

	// Result queue.
	localparam int OUT_DEPTH  = 2;
	localparam int OUT_PTR_W  = 1;
	localparam int OUT_FILL_W = 2;

	// A classified request: saturated stream, counter value, saturated threshold.
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] count;
		logic [THR_W-1:0]  thr;
	} mid_item_t;

	typedef struct packed {
		logic [FRAC_W-1:0] fraction;
		logic              hit;
	} result_t;

endpackage

// ----- rtl/core/cbrs_front.sv -----
`timescale 1ns / 1ps

module cbrs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [cbrs_pkg::IDX_W-1:0]      stream_index,
	input  logic [cbrs_pkg::THR_W-1:0]      threshold,
	output logic                            mid_valid,
	output cbrs_pkg::mid_item_t             mid_item,
	input  logic                            mid_pop
);

	logic [cbrs_pkg::WORD_W-1:0]     cnt_q [cbrs_pkg::STREAM_COUNT];
	cbrs_pkg::mid_item_t             mem_q [cbrs_pkg::MID_DEPTH];
	logic [cbrs_pkg::MID_PTR_W-1:0]  wr_q;
	logic [cbrs_pkg::MID_PTR_W-1:0]  rd_q;
	logic [cbrs_pkg::MID_FILL_W-1:0] fill_q;

	logic                        accept;
	logic [cbrs_pkg::IDX_W-1:0]  idx_sat;
	logic [cbrs_pkg::SEL_W-1:0]  sel;
	logic [cbrs_pkg::THR_W-1:0]  thr_sat;
	cbrs_pkg::mid_item_t         new_item;

	assign full      = (fill_q == cbrs_pkg::MID_FILL_W'(cbrs_pkg::MID_DEPTH));
	assign mid_valid = (fill_q != '0);
	assign mid_item  = mem_q[rd_q];
	assign accept    = push && !full;

	// Out-of-range streams fold onto the last one; thresholds above one clip to one.
	always_comb begin
		if (32'(stream_index) >= cbrs_pkg::STREAM_COUNT) begin
			idx_sat = cbrs_pkg::IDX_W'(cbrs_pkg::STREAM_COUNT - 1);
		end else begin
			idx_sat = stream_index;
		end
		sel = cbrs_pkg::SEL_W'(idx_sat);
		if (threshold > cbrs_pkg::THR_ONE) begin
			thr_sat = cbrs_pkg::THR_ONE;
		end else begin
			thr_sat = threshold;
		end
		new_item.idx   = idx_sat;
		new_item.count = cnt_q[sel];
		new_item.thr   = thr_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbrs_pkg::STREAM_COUNT; i++) begin
				cnt_q[i] <= '0;
			end
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (accept) begin
				cnt_q[sel] <= cnt_q[sel] + cbrs_pkg::WORD_W'(1);
				wr_q       <= wr_q + cbrs_pkg::MID_PTR_W'(1);
			end
			if (mid_pop) begin
				rd_q <= rd_q + cbrs_pkg::MID_PTR_W'(1);
			end
			if (accept && !mid_pop) begin
				fill_q <= fill_q + cbrs_pkg::MID_FILL_W'(1);
			end else if (!accept && mid_pop) begin
				fill_q <= fill_q - cbrs_pkg::MID_FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_q] <= new_item;
		end
	end

endmodule

// ----- rtl/core/cbrs_mix.sv -----
`timescale 1ns / 1ps

module cbrs_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cbrs_pkg::WORD_W-1:0] operand,
	output logic                        done,
	output logic [cbrs_pkg::WORD_W-1:0] result
);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_ONE  = 3'b010,
		M_TWO  = 3'b100
	} mix_state_t;

	localparam int PH_W = 2;
	localparam logic [PH_W-1:0] PH_LOLO = 2'd0;
	localparam logic [PH_W-1:0] PH_LOHI = 2'd1;
	localparam logic [PH_W-1:0] PH_HILO = 2'd2;

	mix_state_t                   state_q;
	logic [PH_W-1:0]              phase_q;
	logic                         done_q;
	logic [cbrs_pkg::WORD_W-1:0]  a_q;
	logic [cbrs_pkg::WORD_W-1:0]  acc_q;
	logic [cbrs_pkg::WORD_W-1:0]  res_q;

	logic [cbrs_pkg::WORD_W-1:0]  v_start;
	logic [cbrs_pkg::WORD_W-1:0]  kmul;
	logic [cbrs_pkg::HALF_W-1:0]  opa;
	logic [cbrs_pkg::HALF_W-1:0]  opb;
	logic [cbrs_pkg::WORD_W-1:0]  prod;
	logic [cbrs_pkg::WORD_W-1:0]  acc_next;

	assign done   = done_q;
	assign result = res_q;

	// The 64-bit product modulo 2^64 is built from three 32x32 partial products,
	// one per cycle: low*low, then the low halves of the two cross terms.
	always_comb begin
		v_start  = operand + cbrs_pkg::GOLDEN_STEP;
		kmul     = (state_q == M_TWO) ? cbrs_pkg::MUL_TWO : cbrs_pkg::MUL_ONE;
		opa      = (phase_q == PH_HILO) ? a_q[cbrs_pkg::WORD_W-1:cbrs_pkg::HALF_W]
		                                : a_q[cbrs_pkg::HALF_W-1:0];
		opb      = (phase_q == PH_LOHI) ? kmul[cbrs_pkg::WORD_W-1:cbrs_pkg::HALF_W]
		                                : kmul[cbrs_pkg::HALF_W-1:0];
		prod     = cbrs_pkg::WORD_W'(opa) * cbrs_pkg::WORD_W'(opb);
		if (phase_q == PH_LOLO) begin
			acc_next = prod;
		end else begin
			acc_next = acc_q + {prod[cbrs_pkg::HALF_W-1:0], cbrs_pkg::HALF_W'(0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			phase_q <= PH_LOLO;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_ONE;
						phase_q <= PH_LOLO;
					end
				end
				M_ONE: begin
					if (phase_q == PH_HILO) begin
						state_q <= M_TWO;
						phase_q <= PH_LOLO;
					end else begin
						phase_q <= phase_q + PH_W'(1);
					end
				end
				M_TWO: begin
					if (phase_q == PH_HILO) begin
						state_q <= M_IDLE;
						phase_q <= PH_LOLO;
						done_q  <= 1'b1;
					end else begin
						phase_q <= phase_q + PH_W'(1);
					end
				end
				default: begin
					state_q <= M_IDLE;
					phase_q <= PH_LOLO;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			a_q <= v_start ^ (v_start >> 30);
		end
		if (state_q == M_ONE || state_q == M_TWO) begin
			acc_q <= acc_next;
		end
		if (state_q == M_ONE && phase_q == PH_HILO) begin
			a_q <= acc_next ^ (acc_next >> 27);
		end
		if (state_q == M_TWO && phase_q == PH_HILO) begin
			res_q <= acc_next ^ (acc_next >> 31);
		end
	end

endmodule

// ----- rtl/core/cbrs_back.sv -----
`timescale 1ns / 1ps

module cbrs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cbrs_pkg::SEED_W-1:0] seed,
	input  logic [cbrs_pkg::ROOM_W-1:0] room,
	input  logic                        mid_valid,
	input  cbrs_pkg::mid_item_t         mid_item,
	output logic                        mid_pop,
	output logic                        mix_start,
	output logic [cbrs_pkg::WORD_W-1:0] mix_operand,
	input  logic                        mix_done,
	input  logic [cbrs_pkg::WORD_W-1:0] mix_result,
	output logic                        empty,
	input  logic                        pop,
	output logic [cbrs_pkg::FRAC_W-1:0] fraction,
	output logic                        hit
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} back_state_t;

	// Which hash the shared finalizer is working on.
	localparam int JOB_W = 2;
	localparam logic [JOB_W-1:0] JOB_ROOM   = 2'd0;
	localparam logic [JOB_W-1:0] JOB_STREAM = 2'd1;
	localparam logic [JOB_W-1:0] JOB_COUNT  = 2'd2;
	localparam logic [JOB_W-1:0] JOB_FINAL  = 2'd3;

	back_state_t                      state_q;
	logic [JOB_W-1:0]                 job_q;
	cbrs_pkg::mid_item_t              item_q;
	logic [cbrs_pkg::WORD_W-1:0]      acc_q;

	cbrs_pkg::result_t                omem_q [cbrs_pkg::OUT_DEPTH];
	logic [cbrs_pkg::OUT_PTR_W-1:0]   owr_q;
	logic [cbrs_pkg::OUT_PTR_W-1:0]   ord_q;
	logic [cbrs_pkg::OUT_FILL_W-1:0]  ofill_q;

	logic                             out_full;
	logic                             push_res;
	logic                             take;
	logic [cbrs_pkg::WORD_W-1:0]      mixed;
	cbrs_pkg::result_t                new_res;

	assign out_full = (ofill_q == cbrs_pkg::OUT_FILL_W'(cbrs_pkg::OUT_DEPTH));
	assign empty    = (ofill_q == '0);
	assign take     = pop && !empty;
	assign fraction = omem_q[ord_q].fraction;
	assign hit      = omem_q[ord_q].hit;
	assign mixed    = acc_q ^ mix_result;

	always_comb begin
		new_res.fraction = mix_result[cbrs_pkg::WORD_W-1:cbrs_pkg::WORD_W-cbrs_pkg::FRAC_W];
		new_res.hit      = cbrs_pkg::THR_W'(new_res.fraction) < item_q.thr;
	end

	always_comb begin
		mid_pop     = 1'b0;
		mix_start   = 1'b0;
		mix_operand = cbrs_pkg::WORD_W'(room);
		push_res    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				// An item is only started when its result is sure to find room.
				if (mid_valid && !out_full) begin
					mid_pop   = 1'b1;
					mix_start = 1'b1;
				end
			end
			B_RUN: begin
				if (mix_done) begin
					unique case (job_q)
						JOB_ROOM: begin
							mix_start   = 1'b1;
							mix_operand = cbrs_pkg::WORD_W'(item_q.idx) + cbrs_pkg::STREAM_BIAS;
						end
						JOB_STREAM: begin
							mix_start   = 1'b1;
							mix_operand = item_q.count + cbrs_pkg::COUNT_BIAS;
						end
						JOB_COUNT: begin
							mix_start   = 1'b1;
							mix_operand = mixed;
						end
						JOB_FINAL: begin
							push_res = 1'b1;
						end
						default: begin
							push_res = 1'b0;
						end
					endcase
				end
			end
			default: begin
				mid_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			job_q   <= JOB_ROOM;
			owr_q   <= '0;
			ord_q   <= '0;
			ofill_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (mid_pop) begin
						state_q <= B_RUN;
						job_q   <= JOB_ROOM;
					end
				end
				B_RUN: begin
					if (mix_done) begin
						job_q <= job_q + JOB_W'(1);
						if (job_q == JOB_FINAL) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (push_res) begin
				owr_q <= owr_q + cbrs_pkg::OUT_PTR_W'(1);
			end
			if (take) begin
				ord_q <= ord_q + cbrs_pkg::OUT_PTR_W'(1);
			end
			if (push_res && !take) begin
				ofill_q <= ofill_q + cbrs_pkg::OUT_FILL_W'(1);
			end else if (!push_res && take) begin
				ofill_q <= ofill_q - cbrs_pkg::OUT_FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			item_q <= mid_item;
			acc_q  <= seed;
		end else if (state_q == B_RUN && mix_done) begin
			acc_q <= mixed;
		end
		if (push_res) begin
			omem_q[owr_q] <= new_res;
		end
	end

endmodule

// ----- rtl/core/counter_based_random_streams_core.sv -----
// An item accepted while the back end is idle shows as a result (empty low) once the back
// end has run four finalizer passes through one shared 32x32 multiplier. The back end
// works on one item at a time; meanwhile the front queue can take up to two more.
// Reset (arst_n low, asynchronous): seed, room and all stream counters go to zero and
// both queues empty; the block is ready in the first cycle after reset is released.
`timescale 1ns / 1ps

module counter_based_random_streams_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [cbrs_pkg::IDX_W-1:0]     stream_index,
	input  logic [cbrs_pkg::THR_W-1:0]     threshold,
	output logic                           empty,
	input  logic                           pop,
	output logic [cbrs_pkg::FRAC_W-1:0]    fraction,
	output logic                           hit,
	input  logic                           cfg_we,
	input  logic [cbrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbrs_pkg::SEED_W-1:0]    cfg_data
);

	// Configuration registers. Writes to indexes past the room register are dropped.
	logic [cbrs_pkg::SEED_W-1:0] seed_q;
	logic [cbrs_pkg::ROOM_W-1:0] room_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			room_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == cbrs_pkg::REG_SEED) begin
				seed_q <= cfg_data;
			end else if (cfg_index == cbrs_pkg::REG_ROOM) begin
				room_q <= cfg_data[cbrs_pkg::ROOM_W-1:0];
			end
		end
	end

	// The front end takes each item, folds the stream index and threshold into range,
	// and post-increments that stream's counter on the spot. Since the counter value is
	// captured at accept time, the back end can lag behind without affecting the order
	// of draws within a stream.
	logic                 mid_valid;
	logic                 mid_pop;
	cbrs_pkg::mid_item_t  mid_item;

	cbrs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.stream_index (stream_index),
		.threshold    (threshold),
		.mid_valid    (mid_valid),
		.mid_item     (mid_item),
		.mid_pop      (mid_pop)
	);

	// The back end sequences the shared finalizer over the room, the biased stream
	// index and the biased counter, XORs those hashes with the seed, and finalizes the
	// XOR once more. The top 53 bits of the last hash are the fraction, and the hit
	// flag compares it against the saturated threshold.
	logic                        mix_start;
	logic                        mix_done;
	logic [cbrs_pkg::WORD_W-1:0] mix_operand;
	logic [cbrs_pkg::WORD_W-1:0] mix_result;

	cbrs_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mix_start),
		.operand (mix_operand),
		.done    (mix_done),
		.result  (mix_result)
	);

	cbrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed        (seed_q),
		.room        (room_q),
		.mid_valid   (mid_valid),
		.mid_item    (mid_item),
		.mid_pop     (mid_pop),
		.mix_start   (mix_start),
		.mix_operand (mix_operand),
		.mix_done    (mix_done),
		.mix_result  (mix_result),
		.empty       (empty),
		.pop         (pop),
		.fraction    (fraction),
		.hit         (hit)
	);

endmodule

// ----- tb/counter_based_random_streams_core_test.sv -----
`timescale 1ns / 1ps

module counter_based_random_streams_core_test;

	// Indexes beyond the two real registers; writes there must leave seed and room alone.
	localparam logic [cbrs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [cbrs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	// The run has about 720 items. The limit below is several times what they need, even
	// with the widest sender gap and the longest receiver hold on every item.
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 140;

	// The receiver changes how it drains results at random intervals.
	typedef enum {DRAIN_STEADY, DRAIN_JITTER, DRAIN_LONG_HOLD, DRAIN_CHOPPY} drain_style_t;

	// Predictor of the block: its own copy of seed, room and stream counters, plus
	// the draws that have been requested but not yet seen on the result side.
	class draw_ledger_t;
		logic [cbrs_pkg::SEED_W-1:0] seed;
		logic [cbrs_pkg::ROOM_W-1:0] room;
		logic [cbrs_pkg::WORD_W-1:0] counters [cbrs_pkg::STREAM_COUNT];
		cbrs_pkg::result_t           awaited_draws [$];
		int unsigned                 faults;

		function new();
			seed = '0;
			room = '0;
			foreach (counters[i])
				counters[i] = '0;
			faults = 0;
		endfunction

		function void set_register(logic [cbrs_pkg::CFG_IDX_W-1:0] index,
			logic [cbrs_pkg::SEED_W-1:0] data);
			case (index)
				cbrs_pkg::REG_SEED: seed = data;
				cbrs_pkg::REG_ROOM: room = data[cbrs_pkg::ROOM_W-1:0];
				default: ;
			endcase
		endfunction

		// The splitmix64 output stage, modulo 2^64 throughout.
		function logic [cbrs_pkg::WORD_W-1:0] splitmix_finish(logic [cbrs_pkg::WORD_W-1:0] v);
			v = v + cbrs_pkg::GOLDEN_STEP;
			v = (v ^ (v >> 30)) * cbrs_pkg::MUL_ONE;
			v = (v ^ (v >> 27)) * cbrs_pkg::MUL_TWO;
			return v ^ (v >> 31);
		endfunction

		function logic [cbrs_pkg::IDX_W-1:0] clamp_stream(logic [cbrs_pkg::IDX_W-1:0] idx);
			if (int'(idx) >= cbrs_pkg::STREAM_COUNT)
				return cbrs_pkg::IDX_W'(cbrs_pkg::STREAM_COUNT - 1);
			return idx;
		endfunction

		// The draw the named stream would give now, without advancing its counter.
		function cbrs_pkg::result_t draw_at(logic [cbrs_pkg::IDX_W-1:0] idx,
			logic [cbrs_pkg::THR_W-1:0] thr);
			logic [cbrs_pkg::IDX_W-1:0]  sel;
			logic [cbrs_pkg::THR_W-1:0]  limit;
			logic [cbrs_pkg::WORD_W-1:0] bits;
			cbrs_pkg::result_t           r;
			sel = clamp_stream(idx);
			limit = (thr > cbrs_pkg::THR_ONE) ? cbrs_pkg::THR_ONE : thr;
			bits = splitmix_finish(seed ^ splitmix_finish(cbrs_pkg::WORD_W'(room))
				^ splitmix_finish(cbrs_pkg::WORD_W'(sel) + cbrs_pkg::STREAM_BIAS)
				^ splitmix_finish(counters[sel] + cbrs_pkg::COUNT_BIAS));
			r.fraction = bits[cbrs_pkg::WORD_W-1 -: cbrs_pkg::FRAC_W];
			r.hit = ({1'b0, r.fraction} < limit);
			return r;
		endfunction

		function logic [cbrs_pkg::FRAC_W-1:0] peek_fraction(logic [cbrs_pkg::IDX_W-1:0] idx);
			cbrs_pkg::result_t r;
			r = draw_at(idx, '0);
			return r.fraction;
		endfunction

		function void note_request(logic [cbrs_pkg::IDX_W-1:0] idx,
			logic [cbrs_pkg::THR_W-1:0] thr);
			logic [cbrs_pkg::IDX_W-1:0] sel;
			sel = clamp_stream(idx);
			awaited_draws.push_back(draw_at(idx, thr));
			counters[sel] = counters[sel] + cbrs_pkg::WORD_W'(1);
		endfunction

		function void check_draw(logic [cbrs_pkg::FRAC_W-1:0] got_fraction, logic got_hit);
			cbrs_pkg::result_t want;
			if (awaited_draws.size() == 0) begin
				$error("result with no request waiting: fraction %h hit %b",
					got_fraction, got_hit);
				faults++;
				return;
			end
			want = awaited_draws.pop_front();
			if (got_fraction !== want.fraction) begin
				$error("fraction: expected %h, actual %h", want.fraction, got_fraction);
				faults++;
			end
			if (got_hit !== want.hit) begin
				$error("hit: expected %b, actual %b", want.hit, got_hit);
				faults++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           push = 1'b0;
	logic                           full;
	logic [cbrs_pkg::IDX_W-1:0]     stream_index = '0;
	logic [cbrs_pkg::THR_W-1:0]     threshold = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	logic [cbrs_pkg::FRAC_W-1:0]    fraction;
	logic                           hit;
	logic                           cfg_we = 1'b0;
	logic [cbrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cbrs_pkg::SEED_W-1:0]    cfg_data = '0;

	draw_ledger_t ledger;
	int unsigned  burst_left = 0;
	int unsigned  cycles = 0;
	int unsigned  stall_left = 0;
	int unsigned  style_left = 0;
	drain_style_t drain_style = DRAIN_STEADY;

	counter_based_random_streams_core DUT (
		.clk,
		.arst_n,
		.push,
		.full,
		.stream_index,
		.threshold,
		.empty,
		.pop,
		.fraction,
		.hit,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog. A hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side. A result is taken at an edge where pop was high and empty low;
	// both are read as they stood before the edge. The pop for the next cycle then
	// follows the current drain style, which is redrawn at random intervals so
	// that steady draining, short jitter and long holds all show up.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				ledger.check_draw(fraction, hit);
			if (style_left == 0) begin
				drain_style = drain_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(50, 300);
			end else begin
				style_left = style_left - 1;
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				case (drain_style)
					DRAIN_JITTER:
						if ($urandom_range(0, 1) == 0)
							stall_left = $urandom_range(1, 3);
					DRAIN_LONG_HOLD:
						if ($urandom_range(0, 7) == 0)
							stall_left = $urandom_range(10, 40);
					DRAIN_CHOPPY:
						if ($urandom_range(0, 2) == 0)
							stall_left = $urandom_range(1, 8);
					default: ;
				endcase
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Thresholds for random items. Besides plain values in range, this mixes in
	// zero, exactly one, values past one (saturation), arbitrary 54-bit words, and
	// the next draw's own fraction and one above it, which sit right on the edge
	// between a miss and a hit.
	function automatic logic [cbrs_pkg::THR_W-1:0] pick_threshold(
		logic [cbrs_pkg::IDX_W-1:0] idx);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return cbrs_pkg::THR_ONE;
			2: return {1'b1, cbrs_pkg::FRAC_W'(rand64())};
			3: return {1'b0, ledger.peek_fraction(idx)};
			4: return {1'b0, ledger.peek_fraction(idx)} + cbrs_pkg::THR_W'(1);
			5: return cbrs_pkg::THR_W'(rand64());
			default: return {1'b0, cbrs_pkg::FRAC_W'(rand64())};
		endcase
	endfunction

	// The sender works in bursts. When a burst runs out it may drop push for a
	// random number of cycles before the next one; sometimes the next burst follows
	// at once, so long unbroken runs occur as well.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Offers one item and returns at the edge that accepts it. Push stays high on
	// return, so a following item goes out back to back.
	task automatic send_draw(input logic [cbrs_pkg::IDX_W-1:0] idx,
		input logic [cbrs_pkg::THR_W-1:0] thr);
		pace_sender();
		push <= 1'b1;
		stream_index <= idx;
		threshold <= thr;
		@(posedge clk);
		while (full)
			@(posedge clk);
		ledger.note_request(idx, thr);
	endtask

	// Stops sending and waits until every requested draw has come back.
	task automatic drain_draws();
		push <= 1'b0;
		while (ledger.awaited_draws.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_register(input logic [cbrs_pkg::CFG_IDX_W-1:0] index,
		input logic [cbrs_pkg::SEED_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		ledger.set_register(index, data);
	endtask

	// Writes both registers, then both spare indexes with junk. The room word is
	// passed at full port width so that bits above the room field get exercised.
	task automatic load_settings(input logic [cbrs_pkg::SEED_W-1:0] seed_word,
		input logic [cbrs_pkg::SEED_W-1:0] room_word);
		put_register(cbrs_pkg::REG_SEED, seed_word);
		put_register(cbrs_pkg::REG_ROOM, room_word);
		put_register(REG_SPARE_LO, rand64());
		put_register(REG_SPARE_HI, rand64());
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [cbrs_pkg::IDX_W-1:0] idx;
		ledger = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items, run on the reset values of seed and room. Every stream
		// is touched once with a corner threshold: zero, one, all ones, just past
		// one, the smallest step, just below one, and both sides of the draw itself.
		send_draw(3'd0, '0);
		send_draw(3'd1, cbrs_pkg::THR_ONE);
		send_draw(3'd2, '1);
		send_draw(3'd3, cbrs_pkg::THR_ONE + cbrs_pkg::THR_W'(1));
		send_draw(3'd4, cbrs_pkg::THR_W'(1));
		send_draw(3'd5, cbrs_pkg::THR_ONE - cbrs_pkg::THR_W'(1));
		send_draw(3'd6, {1'b0, ledger.peek_fraction(3'd6)});
		send_draw(3'd7, {1'b0, ledger.peek_fraction(3'd7)} + cbrs_pkg::THR_W'(1));
		// One stream several times in a row: its counter must step each time while
		// the other streams keep theirs.
		repeat (4)
			send_draw(3'd3, cbrs_pkg::THR_ONE >> 1);
		send_draw(3'd7, {1'b0, ledger.peek_fraction(3'd7)});
		send_draw(3'd0, {1'b0, ledger.peek_fraction(3'd0)} + cbrs_pkg::THR_W'(1));
		send_draw(3'd5, cbrs_pkg::THR_ONE >> 1);
		send_draw(3'd5, '1);
		drain_draws();

		// Random items under a series of settings, the extremes among them. Each
		// setting is loaded only once all earlier draws have come back.
		for (int phase = 1; phase <= 5; phase++) begin
			case (phase)
				1: load_settings('1, '1);
				2: load_settings(rand64(), rand64());
				3: load_settings('0, 64'hffff_ffff_8000_0000);
				4: load_settings(64'h8000_0000_0000_0000, 64'd1);
				default: load_settings(rand64(), rand64());
			endcase
			repeat (RANDOM_PER_PHASE) begin
				idx = cbrs_pkg::IDX_W'($urandom_range(0, (1 << cbrs_pkg::IDX_W) - 1));
				send_draw(idx, pick_threshold(idx));
			end
			drain_draws();
		end

		// Give a stray extra result time to show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.faults == 0 && ledger.awaited_draws.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
